// File: sv/assert_macros.svh
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: sv/aes_cfb_pkg.sv
// Shared types, codes and AES helper functions for the AES-256 CFB / CBC-MAC engine.
// No dependencies.
package aes_cfb_pkg;

  localparam int BLK_W  = 128;
  localparam int NUM_RK = 15;
  localparam int RK_AW  = 4;
  localparam int LAST_RND = 14;

  typedef enum logic [1:0] {
    MODE_CFB_ENC = 2'd0,
    MODE_CFB_DEC = 2'd1,
    MODE_MAC     = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_KEY0  = 3'd0,
    CFG_KEY1  = 3'd1,
    CFG_KEY2  = 3'd2,
    CFG_KEY3  = 3'd3,
    CFG_IV_HI = 3'd4,
    CFG_IV_LO = 3'd5,
    CFG_MODE  = 3'd6,
    CFG_RSVD  = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    mode_t             mode;
    logic              first;
    logic              last;
    logic [BLK_W-1:0]  blk;
  } item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic do_mix);
    logic [7:0] sb [16];
    logic [7:0] t  [16];
    logic [7:0] m  [16];
    logic [7:0] x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      sb[i] = SBOX[s[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = sb[i + 4*((c+i) & 3)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ x ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ x ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ x ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ x ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = do_mix ? m[i] : t[i];
    end
    return r ^ k;
  endfunction

endpackage

// File: sv/aes_cfb_keyexp.sv
// AES-256 key schedule: one round key per cycle into a 15-entry round key store.
// Depends on aes_cfb_pkg.
module aes_cfb_keyexp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [255:0]                     key,
  input  logic [aes_cfb_pkg::RK_AW-1:0]    rd_addr,
  output logic [aes_cfb_pkg::BLK_W-1:0]    rd_data,
  output logic                             busy
);
  import aes_cfb_pkg::*;

  logic [BLK_W-1:0] rk_mem [NUM_RK];
  logic [BLK_W-1:0] rk_q_r;
  logic [BLK_W-1:0] p2_r, p1_r, wdata;
  logic [RK_AW-1:0] cnt_r;
  logic             busy_r;
  logic [31:0]      t, n0, n1, n2, n3;
  logic [7:0]       rcon;

  always_comb begin
    rcon = 8'd1 << 3'(cnt_r[3:1] - 3'd1);
    t = cnt_r[0] ? sub_word(p1_r[31:0])
                 : sub_word({p1_r[23:0], p1_r[31:24]}) ^ {rcon, 24'd0};
    n0 = p2_r[127:96] ^ t;
    n1 = p2_r[95:64] ^ n0;
    n2 = p2_r[63:32] ^ n1;
    n3 = p2_r[31:0] ^ n2;
    case (cnt_r)
      4'd0:    wdata = key[255:128];
      4'd1:    wdata = key[127:0];
      default: wdata = {n0, n1, n2, n3};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == RK_AW'(NUM_RK-1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !start) begin
      rk_mem[cnt_r] <= wdata;
      p2_r <= p1_r;
      p1_r <= wdata;
    end
    rk_q_r <= rk_mem[rd_addr];
  end

  assign rd_data = rk_q_r;
  assign busy    = busy_r;
endmodule

// File: sv/aes_cfb_front.sv
// Input side: accept items, drop the unused mode, hold up to two in a queue.
// Depends on aes_cfb_pkg.
module aes_cfb_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [127:0]           in_tdata,
  input  logic                   in_tuser,
  input  logic                   in_tlast,
  input  aes_cfb_pkg::mode_t     mode,
  input  logic                   hold,
  output logic                   q_valid,
  output aes_cfb_pkg::item_t     q_item,
  input  logic                   q_pop
);
  import aes_cfb_pkg::*;

  item_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      nitem;

  assign in_tready = (cnt_r != 2'd2) && !hold;
  assign push      = in_tvalid && in_tready && (mode != MODE_NONE);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = ent_r[rp_r];

  always_comb begin
    nitem.mode  = mode;
    nitem.first = in_tuser;
    nitem.last  = in_tlast;
    nitem.blk   = {in_tdata[63:0], in_tdata[127:64]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= nitem;
  end
endmodule

// File: sv/aes_cfb_core.sv
// Back end: iterate AES-256 rounds on the chain, apply the mode, hold the result.
// Depends on aes_cfb_pkg; round keys come from aes_cfb_keyexp.
module aes_cfb_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [127:0]                    iv,
  input  logic                            q_valid,
  input  aes_cfb_pkg::item_t              q_item,
  output logic                            q_pop,
  output logic [aes_cfb_pkg::RK_AW-1:0]   rk_addr,
  input  logic [127:0]                    rk,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [127:0]                    out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import aes_cfb_pkg::*;

  bk_state_t         st_r, st_nxt;
  item_t             itm_r;
  logic [RK_AW-1:0]  rnd_r, rnd_nxt;
  logic [127:0]      s_r, s_nxt, chain_r, chain_nxt, cv, res;
  logic              ov_r, ov_nxt, load, emit, out_free, is_mac;
  logic [127:0]      od_r;
  logic              otag_r, olast_r;

  assign out_free = !ov_r || out_tready;
  assign is_mac   = (itm_r.mode == MODE_MAC);
  assign res      = is_mac ? s_r : (itm_r.blk ^ s_r);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:  if (q_valid) st_nxt = BK_ROUND;
      BK_ROUND: if (rnd_r == RK_AW'(LAST_RND)) st_nxt = BK_EMIT;
      BK_EMIT:  if ((is_mac && !itm_r.last) || out_free) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    load  = (st_r == BK_IDLE) && q_valid;
    emit  = (st_r == BK_EMIT) && !(is_mac && !itm_r.last) && out_free;
    q_pop = load;
    cv = q_item.first ? ((q_item.mode == MODE_MAC) ? '0 : iv) : chain_r;
    rnd_nxt   = rnd_r;
    s_nxt     = s_r;
    chain_nxt = chain_r;
    ov_nxt    = ov_r && !out_tready;
    case (st_r)
      BK_IDLE: begin
        rnd_nxt = '0;
        if (load) s_nxt = (q_item.mode == MODE_MAC) ? (cv ^ q_item.blk) : cv;
      end
      BK_ROUND: begin
        s_nxt   = (rnd_r == '0) ? (s_r ^ rk) : aes_round(s_r, rk, rnd_r != RK_AW'(LAST_RND));
        rnd_nxt = rnd_r + 1'b1;
      end
      BK_EMIT: begin
        if (st_nxt == BK_IDLE) begin
          case (itm_r.mode)
            MODE_CFB_ENC: chain_nxt = res;
            MODE_CFB_DEC: chain_nxt = itm_r.blk;
            default:      chain_nxt = s_r;
          endcase
        end
        if (emit) ov_nxt = 1'b1;
      end
      default: rnd_nxt = '0;
    endcase
    rk_addr = rnd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      rnd_r   <= '0;
      ov_r    <= 1'b0;
      chain_r <= '0;
    end else begin
      st_r    <= st_nxt;
      rnd_r   <= rnd_nxt;
      ov_r    <= ov_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    if (load) itm_r <= q_item;
    if (emit) begin
      od_r    <= {res[63:0], res[127:64]};
      otag_r  <= is_mac;
      olast_r <= itm_r.last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = otag_r;
  assign out_tlast  = olast_r;
endmodule

// File: sv/aes256_cfb_and_cbc_mac_engine.sv
// AES-256 CFB-128 encrypt/decrypt and CBC-MAC engine, top level.
// Depends on aes_cfb_pkg, aes_cfb_front, aes_cfb_keyexp, aes_cfb_core, assert_macros.svh.
//
// Channels: in_* takes one 128-bit block per transaction (tuser = first block,
// tlast = last block); out_* returns ciphertext, plaintext or the MAC tag
// (tuser = tag, tlast = end of message); cfg_* writes key words 0..3, IV high,
// IV low and mode at indexes 0..6, other indexes are ignored. cfg_ready is always high.
// From queue to result register each block goes through a load, one initial key add
// and fourteen rounds on the single round unit, then the step that applies
// the mode; the chain feeds the next block, so blocks run one after another.
// A two-entry queue takes input while a block is in flight.
// A key word write starts the key schedule, one round key per cycle;
// in_tready is low meanwhile. After reset the all-zero key is expanded the same way.
// Reset clears the chain, the key, IV and mode registers and the queue.
// When the receiver stalls the result holds in the output register and the
// round unit waits after finishing the next block; the queue fills, then in_tready drops.
// MAC blocks before the last produce no transaction; mode 3 blocks are dropped.
`include "assert_macros.svh"
module aes256_cfb_and_cbc_mac_engine (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // block_high, block_low
  input  logic         in_tuser,   // first_block
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // result_high, result_low
  output logic         out_tuser,  // is_tag
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import aes_cfb_pkg::*;

  logic [255:0]     key_r;
  logic [127:0]     iv_r;
  mode_t            mode_r;
  logic             cfg_we, kx_start, kx_busy, q_valid, q_pop;
  item_t            q_item;
  logic [RK_AW-1:0] rk_addr;
  logic [127:0]     rk;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign kx_start  = cfg_we && (cfg_index == CFG_KEY0 || cfg_index == CFG_KEY1 ||
                                cfg_index == CFG_KEY2 || cfg_index == CFG_KEY3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      iv_r   <= '0;
      mode_r <= MODE_CFB_ENC;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY0:  key_r[255:192] <= cfg_data;
        CFG_KEY1:  key_r[191:128] <= cfg_data;
        CFG_KEY2:  key_r[127:64]  <= cfg_data;
        CFG_KEY3:  key_r[63:0]    <= cfg_data;
        CFG_IV_HI: iv_r[127:64]   <= cfg_data;
        CFG_IV_LO: iv_r[63:0]     <= cfg_data;
        CFG_MODE:  mode_r         <= mode_t'(cfg_data[1:0]);
        default:   ;
      endcase
    end
  end

  aes_cfb_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .mode(mode_r), .hold(kx_busy),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  aes_cfb_keyexp u_keyexp (
    .clk(clk), .rst_n(rst_n), .start(kx_start), .key(key_r),
    .rd_addr(rk_addr), .rd_data(rk), .busy(kx_busy)
  );

  aes_cfb_core u_core (
    .clk(clk), .rst_n(rst_n), .iv(iv_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .rk_addr(rk_addr), .rk(rk),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  `ASSERT_IMPL(a_no_accept_in_keysched, clk, rst_n, kx_busy, !in_tready, "accept during key schedule")
  `ASSERT_IMPL(a_tag_ends_msg, clk, rst_n, out_tvalid && out_tuser, out_tlast, "tag without end of message")
  `ASSERT_HOLDS(a_no_pop_empty, clk, rst_n, !(q_pop && !q_valid), "pop from empty queue")
endmodule
